>>> rtl/bsed_pkg.sv
// types and constants for the backslash escape decoder
// standalone package, used by rtl/backslash_escape_decoder.sv
package bsed_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESCAPED = 3'd1,
    MODE_OCTAL   = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_STOPPED = 3'd4
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] REG_ESCAPE_ENABLE  = 2'd0;
  localparam logic [1:0] REG_APPEND_NEWLINE = 2'd1;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;
  localparam logic [7:0] CH_LX        = 8'h78;
  localparam logic [7:0] CH_LC        = 8'h63;
  localparam logic [7:0] CH_LB        = 8'h62;
  localparam logic [7:0] CH_LE        = 8'h65;
  localparam logic [7:0] CH_LN        = 8'h6e;
  localparam logic [7:0] CH_LR        = 8'h72;
  localparam logic [7:0] CH_LT        = 8'h74;
  localparam logic [7:0] CH_LV        = 8'h76;

  localparam int unsigned RUN_MAX = 3;

endpackage

>>> rtl/backslash_escape_decoder.sv
// backslash escape decoder: word byte stream in, decoded text bytes out
// depends on rtl/bsed_pkg.sv
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | in_text_byte, in_has_byte, in_end_of_word, in_end_of_all
//  out     | out_valid/out_stall| out_byte, out_last_of_run
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// an item is accepted every cycle as long as output keeps up; it is registered in
// the input register, is decoded in one pass and its 0..3 result bytes leave the
// run register one per cycle while out_stall is low, so sustained rate is bounded
// by the output port; the input register and the run register lie between the
// input transfer and the first byte. out_stall holds the run register and backs
// up into in_stall. synchronous active-low reset clears mode, counts and valid
// flags; cfg_ready is always high.
module backslash_escape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_has_byte,
  input  logic       in_end_of_word,
  input  logic       in_end_of_all,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_wdata
);

  logic escape_enable_r, append_newline_r;

  logic       inq_v_r;
  logic [7:0] inq_byte_r;
  logic       inq_has_r, inq_eow_r, inq_all_r;

  bsed_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [8:0]      val_r, val_nxt;

  logic [7:0] run_byte_r [bsed_pkg::RUN_MAX];
  logic [7:0] run_byte_nxt [bsed_pkg::RUN_MAX];
  logic [1:0] run_left_r, run_pos_r, run_n_nxt;

  logic in_xfer, out_xfer, run_free, adv;

  assign cfg_ready = 1'b1;
  assign out_xfer  = out_valid && !out_stall;
  assign run_free  = (run_left_r == 2'd0) || ((run_left_r == 2'd1) && out_xfer);
  assign adv       = inq_v_r && run_free;
  assign in_stall  = inq_v_r && !run_free;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_enable_r  <= 1'b0;
      append_newline_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bsed_pkg::REG_ESCAPE_ENABLE) escape_enable_r <= cfg_wdata;
      if (cfg_index == bsed_pkg::REG_APPEND_NEWLINE) append_newline_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
    end else if (in_xfer) begin
      inq_v_r <= 1'b1;
    end else if (adv) begin
      inq_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      inq_byte_r <= in_text_byte;
      inq_has_r  <= in_has_byte;
      inq_eow_r  <= in_end_of_word | in_end_of_all;
      inq_all_r  <= in_end_of_all;
    end
  end

  // single decode pass over one item
  always_comb begin
    logic [7:0] c;
    logic       ok;
    logic [3:0] d;
    logic [1:0] n;
    logic [7:0] mapped;
    logic       push_c;

    c      = inq_byte_r;
    ok     = 1'b0;
    d      = 4'd0;
    n      = 2'd0;
    mapped = c;
    push_c = 1'b0;
    for (int i = 0; i < bsed_pkg::RUN_MAX; i++) run_byte_nxt[i] = 8'h00;
    cnt_nxt = cnt_r;
    val_nxt = val_r;

    case (mode_r)
      bsed_pkg::MODE_NORMAL, bsed_pkg::MODE_ESCAPED, bsed_pkg::MODE_OCTAL,
      bsed_pkg::MODE_HEX, bsed_pkg::MODE_STOPPED: mode_nxt = mode_r;
      default: mode_nxt = bsed_pkg::MODE_NORMAL;
    endcase

    if (mode_nxt == bsed_pkg::MODE_STOPPED) begin
      if (inq_all_r) begin
        mode_nxt = bsed_pkg::MODE_NORMAL;
        cnt_nxt  = 2'd0;
        val_nxt  = 9'd0;
      end
    end else begin
      if (inq_has_r) begin
        if (!escape_enable_r) begin
          // finish a pending sequence, then pass the byte through
          if (mode_nxt == bsed_pkg::MODE_ESCAPED) begin
            run_byte_nxt[n] = bsed_pkg::CH_BACKSLASH; n = n + 2'd1;
          end else if (mode_nxt == bsed_pkg::MODE_OCTAL || mode_nxt == bsed_pkg::MODE_HEX) begin
            run_byte_nxt[n] = val_nxt[7:0]; n = n + 2'd1;
          end
          mode_nxt = bsed_pkg::MODE_NORMAL; cnt_nxt = 2'd0; val_nxt = 9'd0;
          run_byte_nxt[n] = c; n = n + 2'd1;
        end else begin
          case (mode_nxt)
            bsed_pkg::MODE_ESCAPED: begin
              mode_nxt = bsed_pkg::MODE_NORMAL; cnt_nxt = 2'd0; val_nxt = 9'd0;
              push_c = 1'b1;
              case (c)
                bsed_pkg::CH_ZERO: begin mode_nxt = bsed_pkg::MODE_OCTAL;   push_c = 1'b0; end
                bsed_pkg::CH_LX:   begin mode_nxt = bsed_pkg::MODE_HEX;     push_c = 1'b0; end
                bsed_pkg::CH_LC:   begin mode_nxt = bsed_pkg::MODE_STOPPED; push_c = 1'b0; end
                bsed_pkg::CH_LA:   mapped = 8'd7;
                bsed_pkg::CH_LB:   mapped = 8'd8;
                bsed_pkg::CH_LE:   mapped = 8'd27;
                bsed_pkg::CH_LF:   mapped = 8'd12;
                bsed_pkg::CH_LN:   mapped = 8'd10;
                bsed_pkg::CH_LR:   mapped = 8'd13;
                bsed_pkg::CH_LT:   mapped = 8'd9;
                bsed_pkg::CH_LV:   mapped = 8'd11;
                default:           mapped = c;
              endcase
              if (push_c) begin
                run_byte_nxt[n] = mapped; n = n + 2'd1;
              end
            end
            bsed_pkg::MODE_OCTAL, bsed_pkg::MODE_HEX: begin
              if (c >= bsed_pkg::CH_ZERO && c <= ((mode_nxt == bsed_pkg::MODE_OCTAL) ?
                  bsed_pkg::CH_SEVEN : bsed_pkg::CH_NINE)) begin
                ok = 1'b1; d = 4'(c - bsed_pkg::CH_ZERO);
              end else if (mode_nxt == bsed_pkg::MODE_HEX && c >= bsed_pkg::CH_LA &&
                           c <= bsed_pkg::CH_LF) begin
                ok = 1'b1; d = 4'(c - bsed_pkg::CH_LA + 8'd10);
              end else if (mode_nxt == bsed_pkg::MODE_HEX && c >= bsed_pkg::CH_UA &&
                           c <= bsed_pkg::CH_UF) begin
                ok = 1'b1; d = 4'(c - bsed_pkg::CH_UA + 8'd10);
              end
              if (ok) begin
                if (mode_nxt == bsed_pkg::MODE_OCTAL) val_nxt = {val_nxt[5:0], 3'b000} + 9'(d);
                else                                  val_nxt = {val_nxt[4:0], 4'b0000} + 9'(d);
                cnt_nxt = cnt_nxt + 2'd1;
                if (cnt_nxt >= ((mode_nxt == bsed_pkg::MODE_OCTAL) ? 2'd3 : 2'd2)) begin
                  run_byte_nxt[n] = val_nxt[7:0]; n = n + 2'd1;
                  mode_nxt = bsed_pkg::MODE_NORMAL; cnt_nxt = 2'd0; val_nxt = 9'd0;
                end
              end else begin
                // escape cut short: emit value so far, then treat byte as normal
                run_byte_nxt[n] = val_nxt[7:0]; n = n + 2'd1;
                mode_nxt = bsed_pkg::MODE_NORMAL; cnt_nxt = 2'd0; val_nxt = 9'd0;
                if (c == bsed_pkg::CH_BACKSLASH) mode_nxt = bsed_pkg::MODE_ESCAPED;
                else begin
                  run_byte_nxt[n] = c; n = n + 2'd1;
                end
              end
            end
            default: begin
              if (c == bsed_pkg::CH_BACKSLASH) mode_nxt = bsed_pkg::MODE_ESCAPED;
              else begin
                run_byte_nxt[n] = c; n = n + 2'd1;
              end
            end
          endcase
        end
      end

      if (mode_nxt == bsed_pkg::MODE_STOPPED) begin
        if (inq_all_r) mode_nxt = bsed_pkg::MODE_NORMAL;
      end else if (inq_eow_r) begin
        if (mode_nxt == bsed_pkg::MODE_ESCAPED) begin
          run_byte_nxt[n] = bsed_pkg::CH_BACKSLASH; n = n + 2'd1;
        end else if (mode_nxt == bsed_pkg::MODE_OCTAL || mode_nxt == bsed_pkg::MODE_HEX) begin
          run_byte_nxt[n] = val_nxt[7:0]; n = n + 2'd1;
        end
        mode_nxt = bsed_pkg::MODE_NORMAL; cnt_nxt = 2'd0; val_nxt = 9'd0;
        if (inq_all_r) begin
          if (append_newline_r && n != 2'd3) begin
            run_byte_nxt[n] = bsed_pkg::CH_NEWLINE; n = n + 2'd1;
          end
        end else if (n != 2'd3) begin
          run_byte_nxt[n] = bsed_pkg::CH_SPACE; n = n + 2'd1;
        end
      end
    end
    run_n_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bsed_pkg::MODE_NORMAL;
      cnt_r  <= 2'd0;
      val_r  <= 9'd0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      val_r  <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_left_r <= 2'd0;
      run_pos_r  <= 2'd0;
    end else if (adv) begin
      run_left_r <= run_n_nxt;
      run_pos_r  <= 2'd0;
    end else if (out_xfer) begin
      run_left_r <= run_left_r - 2'd1;
      run_pos_r  <= run_pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < bsed_pkg::RUN_MAX; i++) run_byte_r[i] <= run_byte_nxt[i];
    end
  end

  assign out_valid       = (run_left_r != 2'd0);
  assign out_byte        = (run_pos_r == 2'd0) ? run_byte_r[0] :
                           (run_pos_r == 2'd1) ? run_byte_r[1] : run_byte_r[2];
  assign out_last_of_run = (run_left_r == 2'd1);

  // a new run is only loaded once the previous one is fully transferred
  a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> (run_left_r == 2'd0 || (run_left_r == 2'd1 && out_xfer)))
    else $error("run register overwritten before drained");

  // read position never runs past the three result slots
  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (3'(run_pos_r) + 3'(run_left_r)) <= 3'd3)
    else $error("run position out of range");

  // input side only backs up while an item waits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (inq_v_r && out_valid))
    else $error("input stalled without pending work");

endmodule

>>> bench/backslash_escape_decoder_tb.sv
// testbench for backslash_escape_decoder: directed table, then random word streams
// checked against an in-bench decode predictor; needs rtl/bsed_pkg.sv and the rtl top
`timescale 1ns / 100ps

module backslash_escape_decoder_tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 60;
  localparam int PHASE_ITEMS   = 74;
  localparam int NUM_PHASES    = 6;
  localparam int TIMEOUT_NS    = 2_000_000;

  // control characters produced by the letter escapes
  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0b;
  localparam logic [7:0] CTL_FF  = 8'h0c;
  localparam logic [7:0] CTL_CR  = 8'h0d;
  localparam logic [7:0] CTL_ESC = 8'h1b;

  localparam logic       GOLD     = 1'b1;
  localparam logic       CALC     = 1'b0;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    logic [7:0] text;
    logic       has;
    logic       eow;
    logic       eoa;
  } word_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_out_t;

  typedef struct packed {
    row_kind_t   kind;
    word_item_t  it;
    logic        use_gold;
    logic [1:0]  gold_n;
    logic [23:0] gold;     // first byte in the top bits
    logic [1:0]  reg_idx;
    logic        reg_val;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_has_byte;
  logic       in_end_of_word;
  logic       in_end_of_all;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic       cfg_wdata;

  backslash_escape_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_has_byte     (in_has_byte),
    .in_end_of_word  (in_end_of_word),
    .in_end_of_all   (in_end_of_all),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // decoder state and registers as the bench sees them
  bsed_pkg::mode_t dec_mode;
  logic [1:0] dec_digits;
  logic [8:0] dec_value;
  logic       esc_on;
  logic       nl_on;
  logic [7:0] run_buf [3];
  int         run_len;

  text_out_t  pending_text [$];
  int         text_errors;
  int         src_idle_pct;
  int         sink_stall_pct;
  int         hold_asks;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  function automatic void emit_char(input logic [7:0] c);
    if (run_len < 3) begin
      run_buf[run_len] = c;
      run_len++;
    end
  endfunction

  // close a pending escape: lone backslash or the numeric value so far
  function automatic void finish_sequence();
    if (dec_mode == bsed_pkg::MODE_ESCAPED) emit_char(bsed_pkg::CH_BACKSLASH);
    else if (dec_mode == bsed_pkg::MODE_OCTAL || dec_mode == bsed_pkg::MODE_HEX)
      emit_char(dec_value[7:0]);
    dec_mode   = bsed_pkg::MODE_NORMAL;
    dec_digits = '0;
    dec_value  = '0;
  endfunction

  function automatic void plain_char(input logic [7:0] c);
    if (c == bsed_pkg::CH_BACKSLASH) dec_mode = bsed_pkg::MODE_ESCAPED;
    else emit_char(c);
  endfunction

  function automatic void escape_char(input logic [7:0] c);
    dec_mode   = bsed_pkg::MODE_NORMAL;
    dec_digits = '0;
    dec_value  = '0;
    case (c)
      bsed_pkg::CH_ZERO: dec_mode = bsed_pkg::MODE_OCTAL;
      bsed_pkg::CH_LX:   dec_mode = bsed_pkg::MODE_HEX;
      bsed_pkg::CH_LC:   dec_mode = bsed_pkg::MODE_STOPPED;
      bsed_pkg::CH_LA:   emit_char(CTL_BEL);
      bsed_pkg::CH_LB:   emit_char(CTL_BS);
      bsed_pkg::CH_LE:   emit_char(CTL_ESC);
      bsed_pkg::CH_LF:   emit_char(CTL_FF);
      bsed_pkg::CH_LN:   emit_char(bsed_pkg::CH_NEWLINE);
      bsed_pkg::CH_LR:   emit_char(CTL_CR);
      bsed_pkg::CH_LT:   emit_char(CTL_TAB);
      bsed_pkg::CH_LV:   emit_char(CTL_VT);
      default:           emit_char(c);
    endcase
  endfunction

  function automatic void digit_char(input logic [7:0] c);
    logic       is_oct;
    logic       ok;
    logic [3:0] d;
    logic [7:0] top;
    is_oct = (dec_mode == bsed_pkg::MODE_OCTAL);
    top    = is_oct ? bsed_pkg::CH_SEVEN : bsed_pkg::CH_NINE;
    ok     = 1'b1;
    d      = '0;
    if (c >= bsed_pkg::CH_ZERO && c <= top) d = 4'(c - bsed_pkg::CH_ZERO);
    else if (!is_oct && c >= bsed_pkg::CH_LA && c <= bsed_pkg::CH_LF)
      d = 4'(c - bsed_pkg::CH_LA + 8'd10);
    else if (!is_oct && c >= bsed_pkg::CH_UA && c <= bsed_pkg::CH_UF)
      d = 4'(c - bsed_pkg::CH_UA + 8'd10);
    else ok = 1'b0;
    if (ok) begin
      dec_value  = is_oct ? {dec_value[5:0], 3'b000} + 9'(d)
                          : {dec_value[4:0], 4'b0000} + 9'(d);
      dec_digits = dec_digits + 2'd1;
      if (dec_digits >= (is_oct ? 2'd3 : 2'd2)) finish_sequence();
    end else begin
      // not a digit: the value so far goes out, the byte is taken as plain text
      finish_sequence();
      plain_char(c);
    end
  endfunction

  // fills run_buf with the bytes that one word item produces
  function automatic void decode_word_byte(input word_item_t it);
    logic closes;
    closes  = it.eow | it.eoa;
    run_len = 0;
    if (dec_mode == bsed_pkg::MODE_STOPPED) begin
      if (it.eoa) begin
        dec_mode   = bsed_pkg::MODE_NORMAL;
        dec_digits = '0;
        dec_value  = '0;
      end
      return;
    end
    if (it.has) begin
      if (!esc_on) begin
        finish_sequence();
        emit_char(it.text);
      end else begin
        case (dec_mode)
          bsed_pkg::MODE_NORMAL:  plain_char(it.text);
          bsed_pkg::MODE_ESCAPED: escape_char(it.text);
          default:                digit_char(it.text);
        endcase
      end
    end
    if (dec_mode == bsed_pkg::MODE_STOPPED) begin
      if (it.eoa) dec_mode = bsed_pkg::MODE_NORMAL;
    end else if (closes) begin
      finish_sequence();
      if (!it.eoa) emit_char(bsed_pkg::CH_SPACE);
      else if (nl_on) emit_char(bsed_pkg::CH_NEWLINE);
    end
  endfunction

  // mostly escape material so the decode states get exercised
  function automatic word_item_t random_word_byte();
    word_item_t it;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 20) it.text = bsed_pkg::CH_BACKSLASH;
    else if (pick < 30) it.text = 8'(bsed_pkg::CH_ZERO + $urandom_range(9));
    else if (pick < 38) it.text = 8'(bsed_pkg::CH_LA + $urandom_range(6));
    else if (pick < 43) it.text = 8'(bsed_pkg::CH_UA + $urandom_range(6));
    else if (pick < 49) it.text = bsed_pkg::CH_LX;
    else if (pick < 52) it.text = bsed_pkg::CH_LC;
    else if (pick < 64) begin
      case ($urandom_range(7))
        0: it.text = bsed_pkg::CH_LB;
        1: it.text = bsed_pkg::CH_LE;
        2: it.text = bsed_pkg::CH_LF;
        3: it.text = bsed_pkg::CH_LN;
        4: it.text = bsed_pkg::CH_LR;
        5: it.text = bsed_pkg::CH_LT;
        6: it.text = bsed_pkg::CH_LV;
        default: it.text = bsed_pkg::CH_LA;
      endcase
    end else it.text = 8'($urandom_range(255));
    it.has = ($urandom_range(19) != 0);
    it.eow = ($urandom_range(6) == 0);
    it.eoa = ($urandom_range(29) == 0);
    return it;
  endfunction

  task automatic send_item(input word_item_t it, input logic use_gold,
                           input logic [1:0] gold_n, input logic [23:0] gold);
    text_out_t r;
    int        k;
    in_valid       <= 1'b1;
    in_text_byte   <= it.text;
    in_has_byte    <= it.has;
    in_end_of_word <= it.eow;
    in_end_of_all  <= it.eoa;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    decode_word_byte(it);
    if (use_gold) begin
      for (k = 0; k < int'(gold_n); k++) begin
        r.ch   = gold[23 - 8 * k -: 8];
        r.last = (k == int'(gold_n) - 1);
        pending_text.push_back(r);
      end
    end else begin
      for (k = 0; k < run_len; k++) begin
        r.ch   = run_buf[k];
        r.last = (k == run_len - 1);
        pending_text.push_back(r);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val, input logic lower);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == bsed_pkg::REG_ESCAPE_ENABLE) esc_on = val;
    else if (idx == bsed_pkg::REG_APPEND_NEWLINE) nl_on = val;
    if (lower) cfg_valid <= 1'b0;
  endtask

  // stop offering and let every outstanding byte leave; items with no output
  // may still be in flight, so a few more cycles go by
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : text_sink
    int        hold_left;
    int        hold_done;
    text_out_t want;
    hold_left   = 0;
    hold_done   = 0;
    text_errors = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid !== 1'b0 && out_stall == 1'b0) begin
        if (pending_text.size() == 0) begin
          text_errors++;
          $display("%0t: unexpected transfer, expected none, got byte %02h last %b",
                   $time, out_byte, out_last_of_run);
        end else begin
          want = pending_text.pop_front();
          if (out_byte !== want.ch) begin
            text_errors++;
            $display("%0t: out_byte expected %02h, got %02h", $time, want.ch, out_byte);
          end
          if (out_last_of_run !== want.last) begin
            text_errors++;
            $display("%0t: out_last_of_run expected %b, got %b",
                     $time, want.last, out_last_of_run);
          end
        end
      end
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [31];
    int        phase_idle  [NUM_PHASES];
    int        phase_stall [NUM_PHASES];
    logic      phase_esc   [NUM_PHASES];
    logic      phase_nl    [NUM_PHASES];
    int        p;
    int        n;

    plan = '{
      // escapes off, newline on (reset values)
      '{ROW_ITEM, '{8'h00, 1'b1, 1'b0, 1'b0}, GOLD, 2'd1, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'hff, 1'b1, 1'b1, 1'b0}, GOLD, 2'd2, 24'hff2000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h00, 1'b0, 1'b0, 1'b1}, GOLD, 2'd1, 24'h0a0000, REG_NONE, 1'b0},
      '{ROW_REG,  '{8'h00, 1'b0, 1'b0, 1'b0}, CALC, 2'd0, 24'h0,
        bsed_pkg::REG_ESCAPE_ENABLE, 1'b1},
      '{ROW_REG,  '{8'h00, 1'b0, 1'b0, 1'b0}, CALC, 2'd0, 24'h0,
        bsed_pkg::REG_APPEND_NEWLINE, 1'b0},
      // double backslash
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, GOLD, 2'd1, 24'h5c0000, REG_NONE, 1'b0},
      // \v closing a word
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h76, 1'b1, 1'b1, 1'b0}, GOLD, 2'd2, 24'h0b2000, REG_NONE, 1'b0},
      // \0777 overflows the byte
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h30, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h37, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h37, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h37, 1'b1, 1'b0, 1'b0}, GOLD, 2'd1, 24'hff0000, REG_NONE, 1'b0},
      // \xF cut short by a non-digit
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, CALC, 2'd0, 24'h0, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h78, 1'b1, 1'b0, 1'b0}, CALC, 2'd0, 24'h0, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h46, 1'b1, 1'b0, 1'b0}, CALC, 2'd0, 24'h0, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h67, 1'b1, 1'b0, 1'b0}, CALC, 2'd0, 24'h0, REG_NONE, 1'b0},
      // unknown escape, then a lone backslash at end of word
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h71, 1'b1, 1'b0, 1'b0}, GOLD, 2'd1, 24'h710000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b1, 1'b0}, GOLD, 2'd2, 24'h5c2000, REG_NONE, 1'b0},
      // \c silences everything up to the end of all words
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h63, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h7a, 1'b1, 1'b1, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h00, 1'b0, 1'b0, 1'b1}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_REG,  '{8'h00, 1'b0, 1'b0, 1'b0}, CALC, 2'd0, 24'h0,
        bsed_pkg::REG_APPEND_NEWLINE, 1'b1},
      // bare \0 at end of all, no end-of-word mark
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, CALC, 2'd0, 24'h0, REG_NONE, 1'b0},
      '{ROW_ITEM, '{8'h30, 1'b1, 1'b0, 1'b1}, CALC, 2'd0, 24'h0, REG_NONE, 1'b0},
      // escapes switched off with a backslash pending
      '{ROW_ITEM, '{8'h5c, 1'b1, 1'b0, 1'b0}, GOLD, 2'd0, 24'h000000, REG_NONE, 1'b0},
      '{ROW_REG,  '{8'h00, 1'b0, 1'b0, 1'b0}, CALC, 2'd0, 24'h0,
        bsed_pkg::REG_ESCAPE_ENABLE, 1'b0},
      '{ROW_ITEM, '{8'h6e, 1'b1, 1'b0, 1'b0}, CALC, 2'd0, 24'h0, REG_NONE, 1'b0}
    };
    phase_idle  = '{0, 75, 0, 19, 0, 19};
    phase_stall = '{0, 0, 75, 19, 0, 19};
    phase_esc   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_nl    = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_text_byte   <= '0;
    in_has_byte    <= 1'b0;
    in_end_of_word <= 1'b0;
    in_end_of_all  <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= bsed_pkg::REG_ESCAPE_ENABLE;
    cfg_wdata      <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    dec_mode       = bsed_pkg::MODE_NORMAL;
    dec_digits     = '0;
    dec_value      = '0;
    esc_on         = 1'b0;
    nl_on          = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val, 1'b1);
      end else begin
        send_item(plan[i].it, plan[i].use_gold, plan[i].gold_n, plan[i].gold);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(bsed_pkg::REG_ESCAPE_ENABLE, phase_esc[p], 1'b0);
      write_reg(bsed_pkg::REG_APPEND_NEWLINE, phase_nl[p], 1'b1);
      src_idle_pct   = phase_idle[p];
      sink_stall_pct = phase_stall[p];
      // long sink hold while items keep coming, so the input backs up
      if (p == 0) hold_asks <= hold_asks + 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
        while ($urandom_range(99) < src_idle_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        send_item(random_word_byte(), CALC, 2'd0, 24'h0);
      end
    end

    drain_results();
    if (text_errors == 0 && pending_text.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
